### rtl/cia_pkg.sv
// Package for the checked integer ALU: opcodes, widths and the pipeline stage record.
// No dependencies; every other file in rtl/ uses it by scoped names.
package cia_pkg;

  localparam int unsigned DataW    = 64;
  localparam int unsigned HalfW    = DataW / 2;
  localparam int unsigned ShW      = $clog2(DataW);
  localparam int unsigned DivSteps = DataW;
  localparam int unsigned MulLat   = 3;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_MUL = 4'd2,
    OP_DIV = 4'd3,
    OP_MOD = 4'd4,
    OP_SHL = 4'd5,
    OP_SHR = 4'd6,
    OP_AND = 4'd7,
    OP_OR  = 4'd8,
    OP_XOR = 4'd9,
    OP_ROL = 4'd10,
    OP_ROR = 4'd11
  } op_t;

  // One pipeline slot. rem/dq/mb are the divider working set; dq starts as |a|.
  typedef struct packed {
    logic             v;
    logic [3:0]       op;
    logic [DataW-1:0] res;
    logic             err;
    logic [DataW-1:0] rem;
    logic [DataW-1:0] dq;
    logic [DataW-1:0] mb;
    logic             qneg;
    logic             rneg;
  } stage_t;

endpackage

### rtl/checked_integer_alu.sv
// Top level of the checked 64-bit integer ALU pipeline.
// Depends on cia_pkg, cia_front, cia_mul and cia_div_step.
//
// Usage:
//   Request channel: in_valid/in_ready with op, operand_a, operand_b.
//   Result channel:  out_valid/out_ready with result and error.
//   Every request gives exactly one result, in request order.
//   Path from acceptance to out_valid: front stage, 64 divider stages, a
//   finishing stage and the output register, the same for every op.
//   Throughput: one request per cycle while in_ready is high; the 64-stage
//   restoring divider sets the depth, the multiplier sits in three stages
//   beside its first three steps. Error results always carry result = 1.
//   Reset (rst, synchronous) empties the pipeline, the skid register and the
//   output register; in_ready is high straight after reset.
//   When the receiver stalls, the waiting result stays in the output register
//   and the next finished result goes to a skid register; only while the skid
//   register is full does the pipeline hold and in_ready drop.
module checked_integer_alu (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [3:0]                op,
  input  logic [cia_pkg::DataW-1:0] operand_a,
  input  logic [cia_pkg::DataW-1:0] operand_b,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [cia_pkg::DataW-1:0] result,
  output logic                      error
);

  localparam int unsigned W = cia_pkg::DataW;
  localparam int unsigned N = cia_pkg::DivSteps;

  cia_pkg::stage_t  st [N+1];
  cia_pkg::stage_t  merged;
  logic             en;
  logic [W-1:0]     prod;
  logic             ovf;

  logic             fin_v;
  logic [W-1:0]     fin_res;
  logic             fin_err;
  logic [W-1:0]     fin_res_next;

  logic             skid_v;
  logic [W-1:0]     skid_res;
  logic             skid_err;

  assign en       = !skid_v;
  assign in_ready = !skid_v;

  cia_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .op        (op),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .st        (st[0])
  );

  cia_mul u_mul (
    .clk  (clk),
    .en   (en),
    .ma   (st[0].dq),
    .mb   (st[0].mb),
    .neg  (st[0].qneg),
    .prod (prod),
    .ovf  (ovf)
  );

  // product joins the slot once the multiplier has caught up
  always_comb begin
    merged = st[cia_pkg::MulLat];
    if (cia_pkg::op_t'(merged.op) == cia_pkg::OP_MUL) begin
      merged.res = prod;
      merged.err = ovf;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_div
    if (k == cia_pkg::MulLat) begin : g_merge
      cia_div_step u_step (
        .clk    (clk),
        .rst    (rst),
        .en     (en),
        .st_in  (merged),
        .st_out (st[k+1])
      );
    end else begin : g_plain
      cia_div_step u_step (
        .clk    (clk),
        .rst    (rst),
        .en     (en),
        .st_in  (st[k]),
        .st_out (st[k+1])
      );
    end
  end

  always_comb begin
    case (cia_pkg::op_t'(st[N].op))
      cia_pkg::OP_DIV: fin_res_next = st[N].qneg ? (~st[N].dq + 1'b1) : st[N].dq;
      cia_pkg::OP_MOD: fin_res_next = st[N].rneg ? (~st[N].rem + 1'b1) : st[N].rem;
      default:         fin_res_next = st[N].res;
    endcase
    if (st[N].err) begin
      fin_res_next = {{(W-1){1'b0}}, 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_v <= 1'b0;
    end else if (en) begin
      fin_v <= st[N].v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_res <= fin_res_next;
      fin_err <= st[N].err;
    end
  end

  // output register with skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_v    <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_v) begin
        out_valid <= 1'b1;
        skid_v    <= 1'b0;
      end else begin
        out_valid <= fin_v;
      end
    end else if (fin_v && !skid_v) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      if (skid_v) begin
        result <= skid_res;
        error  <= skid_err;
      end else begin
        result <= fin_res;
        error  <= fin_err;
      end
    end else if (fin_v && !skid_v) begin
      skid_res <= fin_res;
      skid_err <= fin_err;
    end
  end

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> out_valid)
    else $error("skid register full with output register empty");

  a_err_result_one: assert property (@(posedge clk) disable iff (rst)
    (out_valid && error) |-> (result == {{(W-1){1'b0}}, 1'b1}))
    else $error("error result is not one");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_v) |-> $past(out_valid && !out_ready && fin_v))
    else $error("skid filled without a receiver stall");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (skid_v && out_ready) |=> !skid_v)
    else $error("skid register not drained after output taken");

endmodule

### rtl/cia_front.sv
// First pipeline stage: decodes the request, computes the ops done here and
// prepares magnitudes for the multiplier and divider. Uses cia_pkg.
module cia_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [3:0]                   op,
  input  logic [cia_pkg::DataW-1:0]    operand_a,
  input  logic [cia_pkg::DataW-1:0]    operand_b,
  output cia_pkg::stage_t              st
);

  localparam logic [cia_pkg::DataW-1:0] MinNeg = {1'b1, {(cia_pkg::DataW-1){1'b0}}};

  cia_pkg::stage_t                  st_next;
  logic [cia_pkg::DataW-1:0]        sum;
  logic [cia_pkg::DataW-1:0]        diff;
  logic [cia_pkg::DataW-1:0]        ma;
  logic [cia_pkg::DataW-1:0]        mb;
  logic [2*cia_pkg::DataW-1:0]      rol_w;
  logic [2*cia_pkg::DataW-1:0]      ror_w;
  logic [cia_pkg::ShW-1:0]          n;
  logic                             big_sh;
  logic                             sa;
  logic                             sb;

  always_comb begin
    sa     = operand_a[cia_pkg::DataW-1];
    sb     = operand_b[cia_pkg::DataW-1];
    sum    = operand_a + operand_b;
    diff   = operand_a - operand_b;
    ma     = sa ? (~operand_a + 1'b1) : operand_a;
    mb     = sb ? (~operand_b + 1'b1) : operand_b;
    n      = operand_b[cia_pkg::ShW-1:0];
    big_sh = |operand_b[cia_pkg::DataW-1:cia_pkg::ShW];
    rol_w  = {operand_a, operand_a} << n;
    ror_w  = {operand_a, operand_a} >> n;

    st_next      = '0;
    st_next.v    = in_valid;
    st_next.op   = op;
    st_next.rem  = '0;
    st_next.dq   = ma;
    st_next.mb   = mb;
    st_next.qneg = sa ^ sb;
    st_next.rneg = sa;

    unique case (cia_pkg::op_t'(op))
      cia_pkg::OP_ADD: begin
        st_next.res = sum;
        st_next.err = (sa == sb) && (sum[cia_pkg::DataW-1] != sa);
      end
      cia_pkg::OP_SUB: begin
        st_next.res = diff;
        st_next.err = (sa != sb) && (diff[cia_pkg::DataW-1] != sa);
      end
      cia_pkg::OP_MUL: begin
        st_next.err = 1'b0;
      end
      cia_pkg::OP_DIV, cia_pkg::OP_MOD: begin
        st_next.err = (operand_b == '0) || ((operand_a == MinNeg) && (&operand_b));
      end
      cia_pkg::OP_SHL: begin
        st_next.res = operand_a << n;
        st_next.err = big_sh;
      end
      cia_pkg::OP_SHR: begin
        st_next.res = operand_a >> n;
        st_next.err = big_sh;
      end
      cia_pkg::OP_AND: st_next.res = operand_a & operand_b;
      cia_pkg::OP_OR:  st_next.res = operand_a | operand_b;
      cia_pkg::OP_XOR: st_next.res = operand_a ^ operand_b;
      cia_pkg::OP_ROL: st_next.res = rol_w[2*cia_pkg::DataW-1:cia_pkg::DataW];
      cia_pkg::OP_ROR: st_next.res = ror_w[cia_pkg::DataW-1:0];
      default: st_next.err = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.v <= 1'b0;
    end else if (en) begin
      st.v <= st_next.v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st.op   <= st_next.op;
      st.res  <= st_next.res;
      st.err  <= st_next.err;
      st.rem  <= st_next.rem;
      st.dq   <= st_next.dq;
      st.mb   <= st_next.mb;
      st.qneg <= st_next.qneg;
      st.rneg <= st_next.rneg;
    end
  end

endmodule

### rtl/cia_mul.sv
// Three-stage multiplier: 32x32 partial products, column sums, then sign and
// overflow. Runs alongside the divider chain. Uses cia_pkg.
module cia_mul (
  input  logic                      clk,
  input  logic                      en,
  input  logic [cia_pkg::DataW-1:0] ma,
  input  logic [cia_pkg::DataW-1:0] mb,
  input  logic                      neg,
  output logic [cia_pkg::DataW-1:0] prod,
  output logic                      ovf
);

  localparam int unsigned H = cia_pkg::HalfW;
  localparam int unsigned W = cia_pkg::DataW;
  localparam logic [W-1:0] SignBit = {1'b1, {(W-1){1'b0}}};

  logic [W-1:0]   p00;
  logic [W-1:0]   p01;
  logic [W-1:0]   p10;
  logic [W-1:0]   p11;
  logic           neg1;
  logic [W-1:0]   lo;
  logic [W-1:0]   hi;
  logic           neg2;
  logic [W+1:0]   mid;

  always_comb begin
    mid = {2'b00, {H{1'b0}}, p00[W-1:H]} + {2'b00, {H{1'b0}}, p01[H-1:0]}
        + {2'b00, {H{1'b0}}, p10[H-1:0]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p00  <= ma[H-1:0] * mb[H-1:0];
      p01  <= ma[H-1:0] * mb[W-1:H];
      p10  <= ma[W-1:H] * mb[H-1:0];
      p11  <= ma[W-1:H] * mb[W-1:H];
      neg1 <= neg;

      lo   <= {mid[H-1:0], p00[H-1:0]};
      hi   <= p11 + {{H{1'b0}}, p01[W-1:H]} + {{H{1'b0}}, p10[W-1:H]}
            + {{(W-H-2){1'b0}}, mid[W+1:H]};
      neg2 <= neg1;

      prod <= neg2 ? (~lo + 1'b1) : lo;
      ovf  <= (hi != '0) || (neg2 ? (lo > SignBit) : (lo >= SignBit));
    end
  end

endmodule

### rtl/cia_div_step.sv
// One restoring-division stage: brings in one dividend bit and produces one
// quotient bit per enabled cycle; all other fields pass through. Uses cia_pkg.
module cia_div_step (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  cia_pkg::stage_t st_in,
  output cia_pkg::stage_t st_out
);

  localparam int unsigned W = cia_pkg::DataW;

  logic [W-1:0] r2;
  logic         ge;

  always_comb begin
    r2 = {st_in.rem[W-2:0], st_in.dq[W-1]};
    ge = (r2 >= st_in.mb);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_out.v <= 1'b0;
    end else if (en) begin
      st_out.v <= st_in.v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_out.op   <= st_in.op;
      st_out.res  <= st_in.res;
      st_out.err  <= st_in.err;
      st_out.rem  <= ge ? (r2 - st_in.mb) : r2;
      st_out.dq   <= {st_in.dq[W-2:0], ge};
      st_out.mb   <= st_in.mb;
      st_out.qneg <= st_in.qneg;
      st_out.rneg <= st_in.rneg;
    end
  end

endmodule
